// File: rtl/lps_pkg.sv
// lps_pkg: shared types, constants and the arctangent table of the
// lane pursuit steering unit; no dependencies, compiled first
package lps_pkg;

  // field and register widths
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned ANGLE_W    = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // datapath widths
  localparam int unsigned PROD_W  = 50;  // shared multiplier result
  localparam int unsigned VEC_W   = 54;  // cordic x and y
  localparam int unsigned ZACC_W  = 25;  // cordic angle accumulator, Q.16 degrees
  localparam int unsigned TAB_W   = 22;  // arctangent table entry
  localparam int unsigned ITER_W  = 5;   // cordic iteration index

  // cordic table length and iteration default
  localparam int unsigned TABLE_LEN        = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // output limit, 90 degrees in Q7.8
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd23040;

  // register reset values
  localparam logic [DIST_W-1:0]  LOOKAHEAD_RST = 16'd2048;
  localparam logic [DIST_W-1:0]  LENGTH_RST    = 16'd2048;
  localparam logic [SPEED_W-1:0] CRUISE_RST    = 8'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 2'd2;

  // behaviour modes
  typedef enum logic [MODE_W-1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_STOP   = 2'd1,
    MODE_FLIGHT = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H_MUL,
    ST_H_ADD,
    ST_Y_MUL,
    ST_X_MUL,
    ST_X_LOAD,
    ST_NORM,
    ST_ROT,
    ST_FIN
  } lps_state_t;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  function automatic logic [TAB_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
    logic [TAB_W-1:0] v;
    begin
      case (idx)
        5'd0:  v = 22'd2949120;
        5'd1:  v = 22'd1740967;
        5'd2:  v = 22'd919879;
        5'd3:  v = 22'd466945;
        5'd4:  v = 22'd234379;
        5'd5:  v = 22'd117304;
        5'd6:  v = 22'd58666;
        5'd7:  v = 22'd29335;
        5'd8:  v = 22'd14668;
        5'd9:  v = 22'd7334;
        5'd10: v = 22'd3667;
        5'd11: v = 22'd1833;
        5'd12: v = 22'd917;
        5'd13: v = 22'd458;
        5'd14: v = 22'd229;
        5'd15: v = 22'd115;
        5'd16: v = 22'd57;
        5'd17: v = 22'd29;
        5'd18: v = 22'd14;
        5'd19: v = 22'd7;
        5'd20: v = 22'd4;
        5'd21: v = 22'd2;
        5'd22: v = 22'd1;
        default: v = 22'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: rtl/lps_in_if.sv
// lps_in_if: request channel carrying one planning tick
// depends on lps_pkg for field widths
interface lps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [lps_pkg::MODE_W-1:0]            mode;
  logic signed [lps_pkg::COEF_W-1:0]     coef_cubic;
  logic signed [lps_pkg::COEF_W-1:0]     coef_square;
  logic signed [lps_pkg::COEF_W-1:0]     coef_linear;
  logic signed [lps_pkg::COEF_W-1:0]     coef_offset;

  modport source (output valid, mode, coef_cubic, coef_square, coef_linear, coef_offset,
                  input ready);
  modport sink (input valid, mode, coef_cubic, coef_square, coef_linear, coef_offset,
                output ready);
endinterface

// File: rtl/lps_out_if.sv
// lps_out_if: result channel carrying steering angle and speed
// depends on lps_pkg for field widths
interface lps_out_if;
  logic                            valid;
  logic                            ready;
  logic [lps_pkg::ANGLE_W-1:0]     steer_angle;
  logic [lps_pkg::SPEED_W-1:0]     speed_cmd;

  modport source (output valid, steer_angle, speed_cmd, input ready);
  modport sink (input valid, steer_angle, speed_cmd, output ready);
endinterface

// File: rtl/lane_pursuit_steering_unit.sv
// lane_pursuit_steering_unit: pure-pursuit steering on a cubic lane model
// depends on lps_pkg, lps_in_if and lps_out_if
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------
//  in_chan   | in  | valid / ready | mode, coef_cubic/square/linear/offset
//  out_chan  | out | valid / ready | steer_angle, speed_cmd
//  cfg_*     | in  | cfg_we only   | cfg_idx, cfg_wdata (lookahead, length, cruise)
//
// one request at a time; the shared 33x17 multiplier and the cordic adder pair
// serve every step: follow-lane mode runs three horner multiply-add steps, the
// pursuit multiplies and the x load, normalisation shifts, CORDIC_STEPS (max 24)
// rotations and a final state that loads the result, then returns to idle
// before the next request; the other modes go from idle straight to the
// final state
// synchronous active-low reset clears the sequencer, configuration registers and held outputs
// a result waits in the output register; a new request is taken once the
// sequencer is idle, even while that result is still stalled
module lane_pursuit_steering_unit #(
  parameter int unsigned CORDIC_STEPS = lps_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lps_in_if.sink                           in_chan,
  lps_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lps_pkg::*;

  localparam int unsigned STEPS_USED = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(STEPS_USED - 1);

  // control state
  lps_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic [1:0] k_r;
  logic [ITER_W-1:0] i_r;

  // configuration and held outputs
  logic [DIST_W-1:0]  lookahead_r, length_r;
  logic [SPEED_W-1:0] cruise_r;
  logic [ANGLE_W-1:0] last_steer_r;
  logic [SPEED_W-1:0] last_speed_r;

  // payload
  mode_t                    mode_r;
  logic signed [COEF_W-1:0] coef_b_r, coef_c_r, coef_d_r, acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VEC_W-1:0]  xv_r, yv_r;
  logic signed [ZACC_W-1:0] z_r;
  logic [ANGLE_W-1:0]       out_steer_r;
  logic [SPEED_W-1:0]       out_speed_r;

  // combinational nets
  logic                     in_acc, fin_go;
  logic signed [COEF_W-1:0] next_coef;
  logic [COEF_W-1:0]        abs_acc;
  logic signed [32:0]       mul_a;
  logic signed [16:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [38:0]       h_sum;
  logic signed [COEF_W-1:0] h_sat;
  logic signed [VEC_W-1:0]  vmax, xs, ys;
  logic                     norm_done, norm_big;
  logic signed [ZACC_W-1:0] tz, zr;
  logic signed [16:0]       zq;
  logic [ANGLE_W-1:0]       angle, res_steer;
  logic [SPEED_W-1:0]       res_speed;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= LOOKAHEAD_RST;
      length_r    <= LENGTH_RST;
      cruise_r    <= CRUISE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LOOKAHEAD: lookahead_r <= cfg_wdata;
        REG_LENGTH:    length_r    <= cfg_wdata;
        REG_CRUISE:    cruise_r    <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // horner coefficient select
  always_comb begin
    case (k_r)
      2'd0:    next_coef = coef_b_r;
      2'd1:    next_coef = coef_c_r;
      default: next_coef = coef_d_r;
    endcase
  end

  // shared multiplier operand select
  assign abs_acc = acc_r[COEF_W-1] ? COEF_W'(-acc_r) : COEF_W'(acc_r);
  always_comb begin
    case (state_r)
      ST_Y_MUL: begin
        mul_a = signed'({1'b0, abs_acc});
        mul_b = signed'({1'b0, length_r});
      end
      ST_X_MUL: begin
        mul_a = signed'({17'd0, lookahead_r});
        mul_b = signed'({1'b0, lookahead_r});
      end
      default: begin
        mul_a = 33'(acc_r);
        mul_b = signed'({1'b0, lookahead_r});
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // horner accumulate with floor shift and saturation
  assign h_sum = 39'(signed'(prod_r[PROD_W-1:12])) + 39'(next_coef);
  assign h_sat = (h_sum[38:31] == {8{h_sum[31]}}) ? h_sum[31:0]
               : (h_sum[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // normalisation: shift both until the larger reaches bit 49
  assign vmax      = (xv_r > yv_r) ? xv_r : yv_r;
  assign norm_done = (vmax == '0) || vmax[49];
  assign norm_big  = (vmax[49:41] == '0);

  // cordic rotation terms
  assign xs = xv_r >>> i_r;
  assign ys = yv_r >>> i_r;
  assign tz = signed'(ZACC_W'(atan_q16(i_r)));

  // angle rounding and clamp
  assign zr = z_r + 25'sd128;
  assign zq = zr[ZACC_W-1:8];
  always_comb begin
    if (zq < 0) begin
      angle = '0;
    end else if (zq > signed'(17'(ANGLE_MAX))) begin
      angle = ANGLE_MAX;
    end else begin
      angle = zq[ANGLE_W-1:0];
    end
  end

  // result per mode
  always_comb begin
    case (mode_r)
      MODE_FOLLOW: begin
        res_steer = angle;
        res_speed = cruise_r;
      end
      MODE_STOP: begin
        res_steer = last_steer_r;
        res_speed = '0;
      end
      MODE_FLIGHT: begin
        res_steer = '0;
        res_speed = '0;
      end
      default: begin
        res_steer = last_steer_r;
        res_speed = last_speed_r;
      end
    endcase
  end

  // sequencer next state and handshake outputs
  always_comb begin
    state_nxt     = state_r;
    in_chan.ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (mode_t'(in_chan.mode) == MODE_FOLLOW) ? ST_H_MUL : ST_FIN;
        end
      end
      ST_H_MUL:  state_nxt = ST_H_ADD;
      ST_H_ADD:  state_nxt = (k_r == 2'd2) ? ST_Y_MUL : ST_H_MUL;
      ST_Y_MUL:  state_nxt = ST_X_MUL;
      ST_X_MUL:  state_nxt = ST_X_LOAD;
      ST_X_LOAD: state_nxt = ST_NORM;
      ST_NORM:   state_nxt = norm_done ? ST_ROT : ST_NORM;
      ST_ROT:    state_nxt = (i_r == ITER_LAST) ? ST_FIN : ST_ROT;
      ST_FIN:    state_nxt = fin_go ? ST_IDLE : ST_FIN;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
      i_r          <= '0;
      last_steer_r <= '0;
      last_speed_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r  <= 1'b1;
        last_steer_r <= res_steer;
        last_speed_r <= res_speed;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        k_r <= '0;
      end else if (state_r == ST_H_ADD) begin
        k_r <= k_r + 2'd1;
      end
      if (state_r == ST_ROT) begin
        i_r <= i_r + 1'b1;
      end else begin
        i_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= mode_t'(in_chan.mode);
      acc_r    <= in_chan.coef_cubic;
      coef_b_r <= in_chan.coef_square;
      coef_c_r <= in_chan.coef_linear;
      coef_d_r <= in_chan.coef_offset;
    end
    case (state_r)
      ST_H_MUL, ST_Y_MUL: prod_r <= mul_p;
      ST_H_ADD:           acc_r  <= h_sat;
      ST_X_MUL: begin
        prod_r <= mul_p;
        yv_r   <= signed'({3'd0, prod_r, 1'b0});
      end
      ST_X_LOAD: begin
        xv_r <= signed'({prod_r, 4'd0});
        z_r  <= '0;
      end
      ST_NORM: begin
        if (!norm_done) begin
          if (norm_big) begin
            xv_r <= xv_r <<< 8;
            yv_r <= yv_r <<< 8;
          end else begin
            xv_r <= xv_r <<< 1;
            yv_r <= yv_r <<< 1;
          end
        end
      end
      ST_ROT: begin
        if (yv_r > 0) begin
          xv_r <= xv_r + ys;
          yv_r <= yv_r - xs;
          z_r  <= z_r + tz;
        end else if (yv_r < 0) begin
          xv_r <= xv_r - ys;
          yv_r <= yv_r + xs;
          z_r  <= z_r - tz;
        end
      end
      default: ;
    endcase
    if (fin_go) begin
      out_steer_r <= res_steer;
      out_speed_r <= res_speed;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.steer_angle = out_steer_r;
  assign out_chan.speed_cmd   = out_speed_r;

endmodule

// File: rtl/lps_checker.sv
// lps_checker: port-level assertions for the lane pursuit steering unit
// depends on lps_pkg; bound to lane_pursuit_steering_unit below
module lps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lps_pkg::ANGLE_W-1:0]    steer_angle
);
  import lps_pkg::*;

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // steering never exceeds ninety degrees
  a_angle_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> steer_angle <= ANGLE_MAX)
    else $error("steering angle above limit");

  // one request at a time: busy after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind lane_pursuit_steering_unit lps_checker u_lps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .steer_angle (out_chan.steer_angle)
);

// File: dv/lane_pursuit_steering_unit_tb.sv
// lane_pursuit_steering_unit_tb: checks steering angle and speed results against a
// local fixed-point pursuit predictor, under random stalls on both channels
// depends on lps_pkg, lps_in_if, lps_out_if and lane_pursuit_steering_unit
module lane_pursuit_steering_unit_tb;
  import lps_pkg::*;

  localparam int unsigned STEPS          = CORDIC_STEPS_DEF;
  localparam int unsigned ROT_STEPS      = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          LATENCY_CYCLES = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one planning tick request and one steering result
  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] cubic;
    logic signed [31:0] square;
    logic signed [31:0] linear;
    logic signed [31:0] offset;
  } lane_tick_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] steer;
    logic [SPEED_W-1:0] speed;
  } steer_cmd_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lps_in_if  in_chan ();
  lps_out_if out_chan ();

  lane_pursuit_steering_unit #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of registers and held outputs
  logic [DIST_W-1:0]  lookahead_m = LOOKAHEAD_RST;
  logic [DIST_W-1:0]  length_m    = LENGTH_RST;
  logic [SPEED_W-1:0] cruise_spd  = CRUISE_RST;
  logic [ANGLE_W-1:0] held_steer  = '0;
  logic [SPEED_W-1:0] held_speed  = '0;

  steer_cmd_t expected_cmds[$];
  steer_cmd_t want_cmd;
  int error_count      = 0;
  int cycle_count      = 0;
  int tick_gap_pct     = 0;
  int result_stall_pct = 0;
  int stall_request    = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // atan(2^-i) in degrees, Q.16, nearest
  function automatic longint arctan_deg_q16(input int i);
    real deg;
    deg = $atan(2.0 ** (-i)) * 180.0 / $acos(-1.0);
    return longint'(deg * 65536.0);
  endfunction

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // expected outputs of one tick; updates held state
  function automatic steer_cmd_t predict_steering(input lane_tick_t t);
    steer_cmd_t r;
    longint len, acc, mag, yv, xv, xs, ys, z, top;
    r.steer = held_steer;
    r.speed = held_speed;
    case (t.mode)
      MODE_FOLLOW: begin
        // lateral offset at the lookahead by horner, saturating
        len = longint'(lookahead_m);
        acc = longint'($signed(t.cubic));
        acc = sat_q16(((acc * len) >>> 12) + longint'($signed(t.square)));
        acc = sat_q16(((acc * len) >>> 12) + longint'($signed(t.linear)));
        acc = sat_q16(((acc * len) >>> 12) + longint'($signed(t.offset)));
        mag = (acc < 0) ? -acc : acc;
        yv  = 2 * longint'(length_m) * mag;
        xv  = len * len * 16;
        // normalise both terms together
        top = (xv > yv) ? xv : yv;
        while (top != 0 && top < (64'sd1 <<< 49)) begin
          xv  = xv <<< 1;
          yv  = yv <<< 1;
          top = (xv > yv) ? xv : yv;
        end
        // vectoring rotations
        z = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
          xs = xv >>> i;
          ys = yv >>> i;
          if (yv > 0) begin
            xv += ys;
            yv -= xs;
            z  += arctan_deg_q16(i);
          end else if (yv < 0) begin
            xv -= ys;
            yv += xs;
            z  -= arctan_deg_q16(i);
          end
        end
        z = (z + 128) >>> 8;
        if (z < 0) z = 0;
        if (z > longint'(ANGLE_MAX)) z = longint'(ANGLE_MAX);
        r.steer = ANGLE_W'(z);
        r.speed = cruise_spd;
      end
      MODE_STOP: r.speed = '0;
      MODE_FLIGHT: r = '0;
      default: ;
    endcase
    held_steer = r.steer;
    held_speed = r.speed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls and long hold-offs
  always @(negedge clk) begin
    if (stall_request != 0) begin
      out_chan.ready = 1'b0;
      stall_request  = stall_request - 1;
    end else begin
      out_chan.ready = ($urandom_range(99) >= result_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected result, steer_angle", out_chan.steer_angle, 0);
      end else begin
        want_cmd = expected_cmds.pop_front();
        if (out_chan.steer_angle !== want_cmd.steer)
          report_mismatch("steer_angle", out_chan.steer_angle, want_cmd.steer);
        if (out_chan.speed_cmd !== want_cmd.speed)
          report_mismatch("speed_cmd", out_chan.speed_cmd, want_cmd.speed);
      end
    end
  end

  // offer one request, wait for the handshake, then predict
  task automatic send_tick(input lane_tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < tick_gap_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.mode        = t.mode;
    in_chan.coef_cubic  = t.cubic;
    in_chan.coef_square = t.square;
    in_chan.coef_linear = t.linear;
    in_chan.coef_offset = t.offset;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    expected_cmds.push_back(predict_steering(t));
  endtask

  task automatic send_lane(input mode_t m, input int a, input int b, input int c,
                           input int d);
    lane_tick_t t;
    t.mode   = m;
    t.cubic  = a;
    t.square = b;
    t.linear = c;
    t.offset = d;
    send_tick(t);
  endtask

  // release the request channel and let every result come back
  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    case (idx)
      REG_LOOKAHEAD: lookahead_m = data;
      REG_LENGTH:    length_m    = data;
      REG_CRUISE:    cruise_spd  = data[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coef();
    logic signed [31:0] raw;
    raw = $urandom;
    case ($urandom_range(7))
      0:       return '0;
      1, 2:    return raw;
      default: return raw >>> $urandom_range(31);
    endcase
  endfunction

  function automatic lane_tick_t rand_tick();
    lane_tick_t t;
    case ($urandom_range(9))
      6:       t.mode = MODE_STOP;
      7:       t.mode = MODE_FLIGHT;
      8, 9:    t.mode = MODE_HOLD;
      default: t.mode = MODE_FOLLOW;
    endcase
    t.cubic  = rand_coef();
    t.square = rand_coef();
    t.linear = rand_coef();
    t.offset = rand_coef();
    return t;
  endfunction

  task automatic rand_config();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(5))
      0:       v = '0;
      1:       v = '1;
      2:       v = 16'd1;
      default: v = CFG_DATA_W'($urandom) >> $urandom_range(15);
    endcase
    write_reg(CFG_IDX_W'($urandom_range(3)), v);
  endtask

  // held outputs after reset, default registers
  task automatic test_reset_state();
    send_lane(MODE_HOLD, 0, 0, 0, 0);
    send_lane(MODE_STOP, 0, 0, 0, 0);
    send_lane(MODE_FOLLOW, 0, 0, 0, 32'sh0001_0000);
    drain();
  endtask

  // every behaviour mode, including hold after stop and flight
  task automatic test_modes();
    send_lane(MODE_FOLLOW, 32'sh0000_0100, -32'sh0000_2000, 32'sh0000_8000, 32'sh0000_4000);
    send_lane(MODE_STOP, 1, 2, 3, 4);
    send_lane(MODE_HOLD, -1, -1, -1, -1);
    send_lane(MODE_FLIGHT, 5, 6, 7, 8);
    send_lane(MODE_HOLD, 0, 0, 0, 0);
    send_lane(MODE_FOLLOW, 0, 0, 0, -32'sh0000_8000);
    send_lane(MODE_STOP, 0, 0, 0, 0);
    drain();
  endtask

  // coefficient extremes, saturation both ways, zero offset
  task automatic test_coef_extremes();
    send_lane(MODE_FOLLOW, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_lane(MODE_FOLLOW, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_lane(MODE_FOLLOW, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_lane(MODE_FOLLOW, 0, 0, 0, 0);
    drain();
  endtask

  // zero and full lookahead, zero and full length, speed masking, unused index
  task automatic test_reg_extremes();
    write_reg(REG_LOOKAHEAD, '0);
    send_lane(MODE_FOLLOW, 0, 0, 0, 32'sh0000_0010);
    send_lane(MODE_FOLLOW, 32'sh0001_0000, 0, 0, 0);
    drain();
    write_reg(REG_LOOKAHEAD, '1);
    write_reg(REG_LENGTH, '1);
    write_reg(REG_CRUISE, 16'hff55);
    send_lane(MODE_FOLLOW, 32'sh0000_0001, -32'sh0000_0100, 32'sh0000_1000, 32'sh0001_0000);
    drain();
    write_reg(REG_LENGTH, '0);
    write_reg(REG_CRUISE, '0);
    write_reg(REG_UNUSED, 16'hffff);
    send_lane(MODE_FOLLOW, 32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff);
    drain();
    write_reg(REG_LOOKAHEAD, LOOKAHEAD_RST);
    write_reg(REG_LENGTH, LENGTH_RST);
    write_reg(REG_CRUISE, 16'h00ff);
    send_lane(MODE_FOLLOW, 0, 0, 32'sh0000_4000, -32'sh0000_2000);
    drain();
  endtask

  // random ticks, registers changed while idle every few dozen requests
  task automatic test_random(input int count, input int gap_pct, input int stall_pct);
    tick_gap_pct     = gap_pct;
    result_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 39) begin
        drain();
        rand_config();
        rand_config();
      end
      send_tick(rand_tick());
    end
    drain();
  endtask

  // long result hold-off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    lane_tick_t t;
    tick_gap_pct     = 0;
    result_stall_pct = 0;
    @(posedge clk);
    stall_request = 300;
    for (int k = 0; k < 10; k++) begin
      t      = rand_tick();
      t.mode = MODE_FOLLOW;
      send_tick(t);
    end
    drain();
  endtask

  // stimulus sequence
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_LOOKAHEAD;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.mode        = MODE_FOLLOW;
    in_chan.coef_cubic  = '0;
    in_chan.coef_square = '0;
    in_chan.coef_linear = '0;
    in_chan.coef_offset = '0;
    out_chan.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_modes();
    test_coef_extremes();
    test_reg_extremes();
    test_random(220, 19, 73);
    test_backpressure();
    test_random(220, 73, 19);
    test_random(210, 0, 0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
